// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DRSM_ASSERT(lbl, clk, rstn, prop, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rstn) prop) else $error(msg);
`define DRSM_NEVER(lbl, clk, rstn, cond, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DRSM_ASSERT(lbl, clk, rstn, prop, msg)
`define DRSM_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/drsm_pkg.sv =====
// types and codes of the dirty range set merge unit
package drsm_pkg;

    localparam logic [1:0] MODE_MERGE = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_MARK  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // one stored range
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
    } entry_t;

    // request to the shared adder
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } alu_req_t;

endpackage

// ===== rtl/drsm_ram.sv =====
// generic single write port ram with registered read
module drsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/drsm_addsub.sv =====
// shared 32-bit adder/subtractor with carry out
module drsm_addsub
    import drsm_pkg::*;
(
    input  alu_req_t    req,
    output logic [32:0] sum
);

    logic [31:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = {1'b0, req.a} + {1'b0, b_op} + {32'd0, req.sub};

endmodule

// ===== rtl/dirty_range_set_merge_unit.sv =====
// top level: sorted dirty range table with merge sequencer
//
//  channel   direction  handshake           beat
//  command   in         start && !busy      mode, range_begin, range_length, entry_index
//  result    out        done (one cycle)    accepted, all_changed, covered_bytes,
//                                           entry_count, entry_valid, entry_begin,
//                                           entry_length
//
// clear and mark-all finish in idle; a read passes S_RRD then S_RDAT; a merge reads and
// compares each entry searched, reads then writes each entry moved, and reads, compares
// and subtracts each entry absorbed, with the table ram (one read then one write per moved
// entry) and the one shared adder. busy stays high from leaving idle to the result beat.
// reset empties the table and clears the total and the all-changed flag;
// table contents are not cleared, only entries below the count are read.
// the result beat cannot be stalled; a new command may start in the done cycle.
module dirty_range_set_merge_unit
    import drsm_pkg::*;
#(
    parameter int MAX_RANGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] range_begin,
    input  logic [31:0] range_length,
    input  logic [5:0]  entry_index,
    output logic        done,
    output logic        accepted,
    output logic        all_changed,
    output logic [31:0] covered_bytes,
    output logic [6:0]  entry_count,
    output logic        entry_valid,
    output logic [31:0] entry_begin,
    output logic [31:0] entry_length
);

`include "assert_macros.svh"

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_END, S_SRD, S_SCMP, S_NEND, S_DEC, S_TSUB, S_ARD, S_ACMP,
        S_ASUB, S_CRD, S_CWR, S_LEN, S_TADD, S_IRD, S_ISH, S_IWR, S_RRD, S_RDAT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] used_reg, used_next;
    logic [31:0]   total_reg, total_next;
    logic          flag_reg, flag_next;

    // command operands
    logic [31:0] begin_reg, begin_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] end_reg, end_next;

    // search results: entry before and entry at the insert point
    logic [CW-1:0] idx_reg, idx_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [31:0]   prev_start_reg, prev_start_next;
    logic [31:0]   prev_len_reg, prev_len_next;
    logic [31:0]   prev_end_reg, prev_end_next;
    logic          has_nxt_reg, has_nxt_next;
    logic [31:0]   nxt_start_reg, nxt_start_next;
    logic [31:0]   nxt_len_reg, nxt_len_next;
    logic [31:0]   nxt_end_reg, nxt_end_next;

    // grown entry and absorb / compaction pointers
    logic [IW-1:0] m_reg, m_next;
    logic [31:0]   mstart_reg, mstart_next;
    logic [31:0]   mend_reg, mend_next;
    logic [31:0]   sub_len_reg, sub_len_next;
    logic [31:0]   newlen_reg, newlen_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] d_reg, d_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] km1;

    // result beat
    logic        done_reg, done_next;
    logic        acc_reg, acc_next;
    logic        valid_reg, valid_next;
    logic [31:0] eb_reg, eb_next;
    logic [31:0] el_reg, el_next;

    alu_req_t    alu_req;
    logic [32:0] alu_sum;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        rd;
    logic [63:0]   ram_rdata;

    drsm_addsub u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    drsm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd  = ram_rdata;
    assign km1 = k_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        total_next      = total_reg;
        flag_next       = flag_reg;
        begin_next      = begin_reg;
        len_next        = len_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        prev_valid_next = prev_valid_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        prev_end_next   = prev_end_reg;
        has_nxt_next    = has_nxt_reg;
        nxt_start_next  = nxt_start_reg;
        nxt_len_next    = nxt_len_reg;
        nxt_end_next    = nxt_end_reg;
        m_next          = m_reg;
        mstart_next     = mstart_reg;
        mend_next       = mend_reg;
        sub_len_next    = sub_len_reg;
        newlen_next     = newlen_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        k_next          = k_reg;
        done_next       = 1'b0;
        acc_next        = acc_reg;
        valid_next      = valid_reg;
        eb_next         = eb_reg;
        el_next         = el_reg;
        alu_req         = '0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    acc_next   = 1'b1;
                    valid_next = 1'b0;
                    eb_next    = '0;
                    el_next    = '0;
                    unique case (mode)
                        MODE_MERGE:
                        begin
                            begin_next = range_begin;
                            len_next   = range_length;
                            // all-changed or empty range: nothing to do
                            if (flag_reg || range_length == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_END;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            used_next  = '0;
                            total_next = '0;
                            flag_next  = 1'b0;
                            done_next  = 1'b1;
                        end
                        MODE_MARK:
                        begin
                            used_next  = '0;
                            total_next = '0;
                            flag_next  = 1'b1;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            if ({{CW{1'b0}}, entry_index} < {6'd0, used_reg})
                            begin
                                idx_next   = CW'(entry_index);
                                state_next = S_RRD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_END:
            begin
                alu_req = '{a: begin_reg, b: len_reg, sub: 1'b0};
                if (alu_sum[32])
                begin
                    // range end past the address space
                    acc_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    end_next        = alu_sum[31:0];
                    idx_next        = '0;
                    prev_valid_next = 1'b0;
                    has_nxt_next    = 1'b0;
                    state_next      = S_SRD;
                end
            end
            S_SRD:
            begin
                ram_raddr = idx_reg[IW-1:0];
                if (idx_reg == used_reg)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                alu_req = '{a: rd.base, b: rd.size, sub: 1'b0};
                if (rd.base <= begin_reg)
                begin
                    prev_valid_next = 1'b1;
                    prev_start_next = rd.base;
                    prev_len_next   = rd.size;
                    prev_end_next   = alu_sum[31:0];
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_SRD;
                end
                else
                begin
                    nxt_start_next = rd.base;
                    nxt_len_next   = rd.size;
                    state_next     = S_NEND;
                end
            end
            S_NEND:
            begin
                alu_req      = '{a: nxt_start_reg, b: nxt_len_reg, sub: 1'b0};
                nxt_end_next = alu_sum[31:0];
                has_nxt_next = 1'b1;
                state_next   = S_DEC;
            end
            S_DEC:
            begin
                priority if (prev_valid_reg && prev_end_reg >= end_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (prev_valid_reg && prev_end_reg >= begin_reg)
                begin
                    // extend the entry before
                    m_next       = IW'(idx_reg - 1'b1);
                    mstart_next  = prev_start_reg;
                    mend_next    = end_reg;
                    sub_len_next = prev_len_reg;
                    j_next       = idx_reg;
                    state_next   = S_TSUB;
                end
                else if (has_nxt_reg && nxt_start_reg == begin_reg && nxt_end_reg >= end_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (has_nxt_reg && end_reg >= nxt_start_reg)
                begin
                    // pull the next entry down to the new start
                    m_next       = IW'(idx_reg);
                    mstart_next  = begin_reg;
                    mend_next    = (nxt_end_reg > end_reg) ? nxt_end_reg : end_reg;
                    sub_len_next = nxt_len_reg;
                    j_next       = idx_reg + 1'b1;
                    state_next   = S_TSUB;
                end
                else if (used_reg >= CW'(MAX_RANGES))
                begin
                    acc_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = used_reg;
                    state_next = S_IRD;
                end
            end
            S_TSUB:
            begin
                alu_req    = '{a: total_reg, b: sub_len_reg, sub: 1'b1};
                total_next = alu_sum[31:0];
                state_next = S_ARD;
            end
            S_ARD:
            begin
                ram_raddr = j_reg[IW-1:0];
                if (j_reg == used_reg)
                begin
                    d_next     = CW'(m_reg) + 1'b1;
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_ACMP;
                end
            end
            S_ACMP:
            begin
                alu_req = '{a: rd.base, b: rd.size, sub: 1'b0};
                if (mend_reg >= rd.base)
                begin
                    if (alu_sum[31:0] > mend_reg)
                    begin
                        mend_next = alu_sum[31:0];
                    end
                    sub_len_next = rd.size;
                    state_next   = S_ASUB;
                end
                else
                begin
                    d_next     = CW'(m_reg) + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_ASUB:
            begin
                alu_req    = '{a: total_reg, b: sub_len_reg, sub: 1'b1};
                total_next = alu_sum[31:0];
                j_next     = j_reg + 1'b1;
                state_next = S_ARD;
            end
            S_CRD:
            begin
                ram_raddr = j_reg[IW-1:0];
                if (j_reg == used_reg)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = d_reg[IW-1:0];
                ram_wdata  = rd;
                j_next     = j_reg + 1'b1;
                d_next     = d_reg + 1'b1;
                state_next = S_CRD;
            end
            S_LEN:
            begin
                alu_req     = '{a: mend_reg, b: mstart_reg, sub: 1'b1};
                ram_we      = 1'b1;
                ram_waddr   = m_reg;
                ram_wdata   = '{base: mstart_reg, size: alu_sum[31:0]};
                newlen_next = alu_sum[31:0];
                used_next   = d_reg;
                state_next  = S_TADD;
            end
            S_TADD:
            begin
                alu_req    = '{a: total_reg, b: newlen_reg, sub: 1'b0};
                total_next = alu_sum[31:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_IRD:
            begin
                ram_raddr = km1[IW-1:0];
                if (k_reg == idx_reg)
                begin
                    state_next = S_IWR;
                end
                else
                begin
                    state_next = S_ISH;
                end
            end
            S_ISH:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[IW-1:0];
                ram_wdata  = rd;
                k_next     = km1;
                state_next = S_IRD;
            end
            S_IWR:
            begin
                alu_req    = '{a: total_reg, b: len_reg, sub: 1'b0};
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IW-1:0];
                ram_wdata  = '{base: begin_reg, size: len_reg};
                used_next  = used_reg + 1'b1;
                total_next = alu_sum[31:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RRD:
            begin
                ram_raddr  = idx_reg[IW-1:0];
                state_next = S_RDAT;
            end
            S_RDAT:
            begin
                valid_next = 1'b1;
                eb_next    = rd.base;
                el_next    = rd.size;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            total_reg      <= '0;
            flag_reg       <= 1'b0;
            done_reg       <= 1'b0;
            prev_valid_reg <= 1'b0;
            has_nxt_reg    <= 1'b0;
            begin_reg      <= '0;
            len_reg        <= '0;
            end_reg        <= '0;
            idx_reg        <= '0;
            prev_start_reg <= '0;
            prev_len_reg   <= '0;
            prev_end_reg   <= '0;
            nxt_start_reg  <= '0;
            nxt_len_reg    <= '0;
            nxt_end_reg    <= '0;
            m_reg          <= '0;
            mstart_reg     <= '0;
            mend_reg       <= '0;
            sub_len_reg    <= '0;
            newlen_reg     <= '0;
            j_reg          <= '0;
            d_reg          <= '0;
            k_reg          <= '0;
            acc_reg        <= 1'b0;
            valid_reg      <= 1'b0;
            eb_reg         <= '0;
            el_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            flag_reg       <= flag_next;
            done_reg       <= done_next;
            prev_valid_reg <= prev_valid_next;
            has_nxt_reg    <= has_nxt_next;
            begin_reg      <= begin_next;
            len_reg        <= len_next;
            end_reg        <= end_next;
            idx_reg        <= idx_next;
            prev_start_reg <= prev_start_next;
            prev_len_reg   <= prev_len_next;
            prev_end_reg   <= prev_end_next;
            nxt_start_reg  <= nxt_start_next;
            nxt_len_reg    <= nxt_len_next;
            nxt_end_reg    <= nxt_end_next;
            m_reg          <= m_next;
            mstart_reg     <= mstart_next;
            mend_reg       <= mend_next;
            sub_len_reg    <= sub_len_next;
            newlen_reg     <= newlen_next;
            j_reg          <= j_next;
            d_reg          <= d_next;
            k_reg          <= k_next;
            acc_reg        <= acc_next;
            valid_reg      <= valid_next;
            eb_reg         <= eb_next;
            el_reg         <= el_next;
        end
    end

    // status ports show the live state, valid in the done cycle
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign accepted      = acc_reg;
    assign all_changed   = flag_reg;
    assign covered_bytes = total_reg;
    assign entry_count   = 7'(used_reg);
    assign entry_valid   = valid_reg;
    assign entry_begin   = eb_reg;
    assign entry_length  = el_reg;

    `DRSM_NEVER(a_used_max, clk, rst_n, used_reg > CW'(MAX_RANGES), "entry count past table size")
    `DRSM_ASSERT(a_done_idle, clk, rst_n, done_reg |-> state_reg == S_IDLE, "result beat while busy")
    `DRSM_ASSERT(a_cmd_moves, clk, rst_n, (start && !busy) |=> (busy || done_reg), "command dropped")
    `DRSM_ASSERT(a_flag_empty, clk, rst_n, flag_reg |-> used_reg == '0, "entries kept while all changed")

endmodule
